### design/scepl_pkg.sv
// Shared types and constants for the early/prompt/late spreading-code generator.
// Used by scepl_div and spreading_code_early_prompt_late; depends on nothing.
package scepl_pkg;

	// shared divider word width: covers phase + shift magnitude and the code period
	localparam int DIV_W    = 19;
	// cap on effective samples per chip
	localparam int SPC_MAX  = 255;
	// early/late tap offset is samples_per_chip / TAP_DIV
	localparam int TAP_DIV  = 8;
	// half-chip shift: count * samples_per_chip / HALF_DIV
	localparam int HALF_DIV = 2;

	typedef enum logic [1:0] {
		FN_TICK      = 2'd0,
		FN_HALF_CHIP = 2'd1,
		FN_SAMPLE    = 2'd2,
		FN_LOAD      = 2'd3
	} func_t;

	typedef enum logic {
		REG_SPC   = 1'b0,
		REG_CHIPS = 1'b1
	} reg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_QGO,
		S_QWAIT,
		S_IGO,
		S_IWAIT,
		S_RDP,
		S_RDE,
		S_RDL,
		S_WGO,
		S_WWAIT,
		S_DONE
	} state_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] num;
		logic [DIV_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [DIV_W-1:0] quo;
		logic [DIV_W-1:0] rem;
	} div_rsp_t;

endpackage

### design/scepl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module scepl_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1024,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### design/scepl_div.sv
// Shared restoring divider, one quotient bit per cycle (DIV_W steps).
// Depends on scepl_pkg for widths and the request/response structs.
module scepl_div import scepl_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int CNT_W = $clog2(DIV_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0] quo_q;
	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] den_q;
	logic [DIV_W:0]   trial;
	logic [DIV_W:0]   diff;
	logic             fits;

	always_comb begin
		trial = {rem_q, quo_q[DIV_W-1]};
		diff  = trial - {1'b0, den_q};
		fits  = (trial >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - CNT_W'(1);
				end
			end
		end
	end

	// shift the dividend out of the quotient register, one bit per step
	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			quo_q <= req.num;
			rem_q <= '0;
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign rsp = '{busy: busy_q, done: done_q, quo: quo_q, rem: rem_q};

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("divider done without a preceding step");

	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (rem_q < den_q))
		else $error("partial remainder reached the divisor");

	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("divider started while busy");

endmodule

### design/spreading_code_early_prompt_late.sv
// Top level of the early/prompt/late spreading-code replica generator.
// Depends on scepl_pkg, scepl_div (shared divider) and scepl_ram (chip table).
//
// Usage:
//   Input words arrive on s_axis_*: tuser carries the function (sample tick,
//   half-chip shift, sample shift, chip load), tdata the operands. Each word
//   yields one output word on m_axis_* with the prompt, early and late chips
//   and the code phase as they stood before the word acted.
//   Load the chip table with load words before reading any chip; entries
//   never written read back as garbage.
//   The APB port holds samples_per_chip (0x0) and chip_count (0x4); change
//   them only while the block is idle.
// Timing:
//   One radix-2 divider does all three divisions (phase / samples_per_chip,
//   chip number mod chip_count, and the wrap of the new phase mod period),
//   19 steps each, and the chip table is read once per tap through its
//   single read port; load words skip the wrap division. s_axis_tready is
//   high only between words, so the block takes no new input word until the
//   last one has gone to the output register.
// Reset:
//   arst_n clears the phase to zero, the registers to 8 samples per chip and
//   255 chips, and empties the output register. The chip table is not cleared.
// Backpressure:
//   A finished word waits in the output register while the next input word is
//   accepted and worked on; the engine holds at its last step until the
//   output register frees up.
module spreading_code_early_prompt_late import scepl_pkg::*; #(
	parameter int MAX_CHIPS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // [8:0] half_chip_shift, [25:9] sample_shift,
	                                   // [35:26] load_index, [36] load_bit, [39:37] zero
	input  logic [1:0]  s_axis_tuser,  // [1:0] func
	// output stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // [0] prompt_chip, [1] early_chip, [2] late_chip,
	                                   // [20:3] code_phase, [23:21] zero
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int AW = $clog2(MAX_CHIPS);

	// configuration registers
	logic [7:0]  spc_q;
	logic [10:0] chips_q;
	logic [7:0]  spc_eff;
	logic [10:0] chips_eff;
	logic [7:0]  tap;
	logic        cfg_wr;

	// sequencer and state
	state_t      state_q;
	state_t      state_d;
	logic [17:0] phase_q;

	// latched input word
	func_t              func_q;
	logic signed [8:0]  half_q;
	logic signed [16:0] sshift_q;
	logic [9:0]         lidx_q;
	logic               lbit_q;

	// working registers
	logic signed [17:0] prod_q;
	logic [DIV_W-1:0]   period_q;
	logic signed [19:0] sum_q;
	logic [DIV_W-1:0]   qp_q;
	logic               einc_q;
	logic               ldec_q;
	logic [AW-1:0]      pidx_q;
	logic               prompt_q;
	logic               early_q;
	logic               late_q;
	logic [17:0]        newph_q;

	logic signed [17:0] delta;
	logic [DIV_W-1:0]   sum_abs;
	logic [AW-1:0]      last_idx;
	logic [AW-1:0]      eidx;
	logic [AW-1:0]      lidx;
	logic               idx_ok;

	// output register
	logic        out_valid_q;
	logic        out_prompt_q;
	logic        out_early_q;
	logic        out_late_q;
	logic [17:0] out_phase_q;
	logic        out_free;
	logic        out_load;

	// shared units
	div_req_t      div_req;
	div_rsp_t      div_rsp;
	logic          ram_we;
	logic [AW-1:0] ram_raddr;
	logic          ram_rdata;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spc_q   <= 8'd8;
			chips_q <= 11'd255;
		end else if (cfg_wr) begin
			unique case (reg_idx_t'(paddr[2]))
				REG_SPC:   spc_q   <= pwdata[7:0];
				REG_CHIPS: chips_q <= pwdata[10:0];
				default:   ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[2]))
			REG_SPC:   prdata = {24'd0, spc_q};
			REG_CHIPS: prdata = {21'd0, chips_q};
			default:   prdata = '0;
		endcase
	end

	// zero means one; clamp both to their supported maximum
	always_comb begin
		spc_eff = spc_q;
		if (spc_q == '0) begin
			spc_eff = 8'd1;
		end else if (32'(spc_q) > SPC_MAX) begin
			spc_eff = 8'(SPC_MAX);
		end
		chips_eff = chips_q;
		if (chips_q == '0) begin
			chips_eff = 11'd1;
		end else if (32'(chips_q) > MAX_CHIPS) begin
			chips_eff = 11'(MAX_CHIPS);
		end
	end

	assign tap = 8'(spc_eff / TAP_DIV);

	// ---------------- datapath helpers ----------------
	always_comb begin
		case (func_q)
			FN_TICK:      delta = 18'sd1;
			FN_HALF_CHIP: delta = 18'(prod_q / HALF_DIV);   // truncates toward zero
			FN_SAMPLE:    delta = 18'(sshift_q);
			FN_LOAD:      delta = '0;
		endcase
	end

	assign sum_abs = sum_q[19] ? DIV_W'(-sum_q) : DIV_W'(sum_q);

	// early and late chip numbers are the prompt one stepped by at most one,
	// wrapping around the code period
	assign last_idx = AW'(chips_eff - 11'd1);
	assign eidx = !einc_q ? pidx_q : ((pidx_q == last_idx) ? '0 : pidx_q + AW'(1));
	assign lidx = !ldec_q ? pidx_q : ((pidx_q == '0) ? last_idx : pidx_q - AW'(1));
	assign idx_ok = (32'(lidx_q) < MAX_CHIPS);

	assign out_free = !out_valid_q || m_axis_tready;

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		div_req   = '{start: 1'b0, num: '0, den: '0};
		ram_raddr = pidx_q;
		ram_we    = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (s_axis_tvalid) begin
					state_d = S_QGO;
				end
			end
			S_QGO: begin
				// chip number and offset within the chip
				div_req = '{start: 1'b1, num: DIV_W'(phase_q), den: DIV_W'(spc_eff)};
				state_d = S_QWAIT;
			end
			S_QWAIT: begin
				if (div_rsp.done) begin
					state_d = S_IGO;
				end
			end
			S_IGO: begin
				// chip number folded into the code period
				div_req = '{start: 1'b1, num: qp_q, den: DIV_W'(chips_eff)};
				state_d = S_IWAIT;
			end
			S_IWAIT: begin
				if (div_rsp.done) begin
					state_d = S_RDP;
				end
			end
			S_RDP: begin
				ram_raddr = pidx_q;
				state_d   = S_RDE;
			end
			S_RDE: begin
				ram_raddr = eidx;
				state_d   = S_RDL;
			end
			S_RDL: begin
				ram_raddr = lidx;
				state_d   = S_WGO;
			end
			S_WGO: begin
				if (func_q == FN_LOAD) begin
					state_d = S_DONE;
				end else begin
					div_req = '{start: 1'b1, num: sum_abs, den: period_q};
					state_d = S_WWAIT;
				end
			end
			S_WWAIT: begin
				if (div_rsp.done) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				// hold here until the output register can take the word
				if (out_free) begin
					out_load = 1'b1;
					ram_we   = (func_q == FN_LOAD) && idx_ok;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign s_axis_tready = (state_q == S_IDLE);

	// ---------------- working registers ----------------
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && s_axis_tvalid) begin
			func_q   <= func_t'(s_axis_tuser);
			half_q   <= s_axis_tdata[8:0];
			sshift_q <= s_axis_tdata[25:9];
			lidx_q   <= s_axis_tdata[35:26];
			lbit_q   <= s_axis_tdata[36];
		end
		if (state_q == S_QGO) begin
			prod_q   <= half_q * $signed({1'b0, spc_eff});
			period_q <= DIV_W'(spc_eff) * DIV_W'(chips_eff);
		end
		if (state_q == S_QWAIT && div_rsp.done) begin
			qp_q   <= div_rsp.quo;
			einc_q <= (div_rsp.rem + DIV_W'(tap)) >= DIV_W'(spc_eff);
			ldec_q <= div_rsp.rem < DIV_W'(tap);
		end
		if (state_q == S_IGO) begin
			sum_q <= 20'({2'b00, phase_q}) + 20'(delta);
		end
		if (state_q == S_IWAIT && div_rsp.done) begin
			pidx_q <= AW'(div_rsp.rem);
		end
		// table data arrives the cycle after its address (registered read)
		if (state_q == S_RDE) begin
			prompt_q <= ram_rdata;
		end
		if (state_q == S_RDL) begin
			early_q <= ram_rdata;
		end
		if (state_q == S_WGO) begin
			late_q <= ram_rdata;
		end
		// floored modulo: a negative sum with a remainder wraps from the top
		if (state_q == S_WWAIT && div_rsp.done) begin
			if (sum_q[19] && div_rsp.rem != '0) begin
				newph_q <= 18'(period_q - div_rsp.rem);
			end else begin
				newph_q <= 18'(div_rsp.rem);
			end
		end
		if (out_load) begin
			out_prompt_q <= prompt_q;
			out_early_q  <= early_q;
			out_late_q   <= late_q;
			out_phase_q  <= phase_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load && func_q != FN_LOAD) begin
				phase_q <= newph_q;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, out_phase_q, out_late_q, out_early_q, out_prompt_q};

	// ---------------- shared units ----------------
	scepl_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	scepl_ram #(
		.WIDTH (1),
		.DEPTH (MAX_CHIPS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(lidx_q)),
		.wdata (lbit_q),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// ---------------- checks ----------------
	a_prompt_in_period: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RDP) |-> (32'(pidx_q) < 32'(chips_eff)))
		else $error("prompt chip index outside the code period");

	a_phase_wrapped: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && func_q != FN_LOAD) |=> (DIV_W'(phase_q) < period_q))
		else $error("updated phase not reduced into the period");

	a_done_to_output: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (m_axis_tvalid && state_q == S_IDLE))
		else $error("finished word did not reach the output register");

endmodule

### tb/spreading_code_early_prompt_late_test.sv
// Self-checking testbench for the early/prompt/late spreading-code generator.
// Depends on scepl_pkg and spreading_code_early_prompt_late; predicts every output word
// from its own copy of the phase, the registers and the chip table.
module spreading_code_early_prompt_late_test;
	import scepl_pkg::*;

	localparam int TABLE_DEPTH  = 1024;
	localparam int FILL_CHIPS   = 256;
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int RANDOM_WORDS = 230;
	localparam int QUIET_WORDS  = 40;

	// one expected output word; known[i] clears when a tap lands on a chip never loaded
	typedef struct packed {
		logic [2:0]  chips;  // [0] prompt, [1] early, [2] late
		logic [2:0]  known;
		logic [17:0] phase;
	} taps_t;

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata  = '0;
	logic [1:0]  s_axis_tuser  = FN_TICK;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	logic        psel          = 1'b0;
	logic        penable       = 1'b0;
	logic        pwrite        = 1'b0;
	logic [2:0]  paddr         = '0;
	logic [31:0] pwdata        = '0;
	logic [31:0] prdata;
	logic        pready;

	// replica of the block state, advanced at every accepted input word
	logic [7:0]  spc_reg       = 8'd8;
	logic [10:0] chips_reg     = 11'd255;
	logic [17:0] replica_phase = '0;
	bit          chip_image   [TABLE_DEPTH];
	bit          chip_written [TABLE_DEPTH];
	taps_t       expected_taps [$];

	int  errors;
	int  words_sent;
	int  words_checked;
	int  config_writes;
	int  cycle_count;
	bit  sender_gaps     = 1'b1;
	bit  receiver_stalls = 1'b1;

	string tap_names [3] = '{"prompt", "early", "late"};

	spreading_code_early_prompt_late #(
		.MAX_CHIPS(TABLE_DEPTH)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// hard stop in case the block hangs
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: run exceeded %0d cycles, %0d words still expected",
				$time, CYCLE_LIMIT, expected_taps.size());
			$display("FAIL spreading_code_early_prompt_late");
			$finish;
		end
	end

	function automatic longint floor_quot(longint a, longint b);
		longint q;
		q = a / b;
		if ((a % b) != 0 && a < 0)
			q -= 1;
		return q;
	endfunction

	function automatic longint floor_rem(longint a, longint b);
		longint r;
		r = a % b;
		if (r < 0)
			r += b;
		return r;
	endfunction

	// Report the taps as the phase stands, then apply the word to the replica.
	task automatic predict_taps(input func_t fn, input logic [39:0] d);
		longint spc, chips, ph, tap, delta;
		longint idx [3];
		taps_t  t;
		spc   = (spc_reg == 0) ? 1 : spc_reg;
		if (spc > SPC_MAX)
			spc = SPC_MAX;
		chips = (chips_reg == 0) ? 1 : ((chips_reg > TABLE_DEPTH) ? TABLE_DEPTH : chips_reg);
		ph    = replica_phase;
		tap   = spc / TAP_DIV;
		delta = 0;
		// taps wrap modulo the chip count even when the phase sits past the period
		idx[0] = floor_rem(ph / spc, chips);
		idx[1] = floor_rem((ph + tap) / spc, chips);
		// late tap floors, so just behind chip zero it lands on the last chip
		idx[2] = floor_rem(floor_quot(ph - tap, spc), chips);
		for (int i = 0; i < 3; i++) begin
			t.chips[i] = chip_image[idx[i]];
			t.known[i] = chip_written[idx[i]];
		end
		t.phase = replica_phase;
		expected_taps = {expected_taps, t};
		case (fn)
			FN_TICK: delta = 1;
			// half-chip move truncates toward zero, as signed division does
			FN_HALF_CHIP: delta = (longint'($signed(d[8:0])) * spc) / HALF_DIV;
			FN_SAMPLE: delta = longint'($signed(d[25:9]));
			default: begin
				chip_image[d[35:26]]   = d[36];
				chip_written[d[35:26]] = 1'b1;
			end
		endcase
		if (fn != FN_LOAD)
			replica_phase = 18'(floor_rem(ph + delta, spc * chips));
	endtask

	// Send one input word; operand fills the field the function uses, the rest is random bar the zero top bits.
	task automatic send_word(input func_t fn, input int operand, input bit load_val);
		logic [39:0] d;
		d[31:0]  = $urandom;
		d[39:32] = 8'($urandom);
		d[39:37] = 3'b000;
		case (fn)
			FN_HALF_CHIP: d[8:0] = operand[8:0];
			FN_SAMPLE: d[25:9] = operand[16:0];
			FN_LOAD: begin
				d[35:26] = operand[9:0];
				d[36]    = load_val;
			end
			default: ;
		endcase
		if (sender_gaps && $urandom_range(0, 3) == 0) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(0, 4)) @(negedge clk);
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= d;
		s_axis_tuser  <= fn;
		do @(posedge clk); while (!s_axis_tready);
		predict_taps(fn, d);
		words_sent++;
	endtask

	// Drop valid and hold until every expected word has come back.
	task automatic wait_drained();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (expected_taps.size() != 0)
			@(posedge clk);
	endtask

	// Write one register over APB, then read it back.
	task automatic cfg_write(input reg_idx_t idx, input logic [31:0] value);
		logic [31:0] mask;
		mask = (idx == REG_SPC) ? 32'h0000_00FF : 32'h0000_07FF;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == REG_SPC)
			spc_reg = value[7:0];
		else
			chips_reg = value[10:0];
		config_writes++;
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== (value & mask)) begin
			$display("%0t: register %s readback expected 0x%0h got 0x%0h",
				$time, idx.name(), value & mask, prdata);
			errors++;
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Change both registers only once the block has gone idle.
	task automatic set_config(input int spc, input int chips);
		wait_drained();
		cfg_write(REG_SPC, spc);
		cfg_write(REG_CHIPS, chips);
	endtask

	// Ticks most often, as in tracking, with shifts of both kinds and table rewrites.
	task automatic send_random_word();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4)
			send_word(FN_TICK, 0, 1'b0);
		else if (r < 6)
			send_word(FN_HALF_CHIP,
				$urandom_range(0, 1) ? int'($urandom_range(0, 511)) : int'($urandom_range(0, 8)) - 4,
				1'b0);
		else if (r < 8)
			send_word(FN_SAMPLE,
				$urandom_range(0, 1) ? int'($urandom) : int'($urandom_range(0, 40)) - 20, 1'b0);
		else
			send_word(FN_LOAD, $urandom_range(0, TABLE_DEPTH - 1), $urandom_range(0, 1));
	endtask

	// Load the low part of the table and its last entry with one chip in use, so
	// only entry zero is tapped meanwhile. Later chip counts stay within the loaded
	// part, except where the phase sits at the wrap of the full-table period and a
	// tap lands on the last entry. The very first word taps entry zero before
	// anything is loaded; its chips are left unchecked.
	task automatic test_table_fill();
		set_config(1, 1);
		for (int i = 0; i < FILL_CHIPS; i++)
			send_word(FN_LOAD, i, $urandom_range(0, 1));
		send_word(FN_LOAD, TABLE_DEPTH - 1, $urandom_range(0, 1));
	endtask

	task automatic test_corners();
		// late tap wraps to the last chip at phase zero; half-chip step back wraps
		set_config(8, 255);
		send_word(FN_TICK, 0, 1'b0);
		send_word(FN_HALF_CHIP, -1, 1'b0);
		send_word(FN_SAMPLE, 2, 1'b0);
		send_word(FN_TICK, 0, 1'b0);
		// odd samples per chip: half-chip moves truncate toward zero; field extremes
		set_config(7, 255);
		send_word(FN_HALF_CHIP, -1, 1'b0);
		send_word(FN_HALF_CHIP, 255, 1'b0);
		send_word(FN_HALF_CHIP, -256, 1'b0);
		send_word(FN_SAMPLE, 65535, 1'b0);
		send_word(FN_SAMPLE, -65536, 1'b0);
		send_word(FN_TICK, 0, 1'b0);
		// largest period: step the phase back and forth by one sample
		set_config(255, 1024);
		send_word(FN_SAMPLE, -1, 1'b0);
		send_word(FN_TICK, 0, 1'b0);
		send_word(FN_SAMPLE, -1, 1'b0);
		// zero registers read as one; phase now far past the period
		set_config(0, 0);
		send_word(FN_TICK, 0, 1'b0);
		send_word(FN_TICK, 0, 1'b0);
		// chip count above the table saturates; load both ends of the table
		set_config(1, 2047);
		send_word(FN_SAMPLE, -1, 1'b0);
		send_word(FN_TICK, 0, 1'b0);
		send_word(FN_LOAD, TABLE_DEPTH - 1, 1'b1);
		send_word(FN_LOAD, 0, 1'b0);
		send_word(FN_TICK, 0, 1'b0);
	endtask

	task automatic test_random_tracking();
		int spc_pick   [5];
		int chips_pick [5];
		int per_phase;
		spc_pick   = '{255, 1, 0, int'($urandom_range(1, 255)), int'($urandom_range(0, 255))};
		chips_pick = '{FILL_CHIPS, 2, 0, int'($urandom_range(1, FILL_CHIPS)),
			int'($urandom_range(0, FILL_CHIPS))};
		per_phase  = RANDOM_WORDS / 5;
		for (int p = 0; p < 5; p++) begin
			// no phase reset here, so a shrinking period leaves the phase beyond it
			set_config(spc_pick[p], chips_pick[p]);
			for (int n = 0; n < per_phase; n++) begin
				// hold the sender once until the block has emptied
				if (p == 2 && n == per_phase / 2)
					wait_drained();
				send_random_word();
			end
		end
	endtask

	task automatic test_back_to_back();
		set_config($urandom_range(1, 255), $urandom_range(1, FILL_CHIPS));
		sender_gaps     = 1'b0;
		receiver_stalls = 1'b0;
		for (int n = 0; n < QUIET_WORDS; n++)
			send_random_word();
	endtask

	// receiver: drop ready at random to stall the output
	initial begin
		forever begin
			@(negedge clk);
			if (receiver_stalls && $urandom_range(0, 3) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(0, 4)) @(negedge clk);
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// compare each output word with the oldest expectation
	always @(posedge clk) begin
		taps_t t;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_taps.size() == 0) begin
				$display("%0t: output word 0x%0h with nothing expected", $time, m_axis_tdata);
				errors++;
			end else begin
				t = expected_taps.pop_front();
				words_checked++;
				if (m_axis_tdata[20:3] !== t.phase) begin
					$display("%0t: code_phase expected %0d got %0d",
						$time, t.phase, m_axis_tdata[20:3]);
					errors++;
				end
				for (int i = 0; i < 3; i++) begin
					if (t.known[i] && m_axis_tdata[i] !== t.chips[i]) begin
						$display("%0t: %s_chip expected %0b got %0b",
							$time, tap_names[i], t.chips[i], m_axis_tdata[i]);
						errors++;
					end
				end
			end
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_table_fill();
		test_corners();
		test_random_tracking();
		test_back_to_back();

		wait_drained();
		repeat (80) @(posedge clk);
		$display("Covered %0d input words (%0d checked) over %0d register writes,",
			words_sent, words_checked, config_writes);
		$display("including zero and saturated registers, wraps and phase past the period.");
		if (errors == 0 && expected_taps.size() == 0)
			$display("PASS spreading_code_early_prompt_late");
		else
			$display("FAIL spreading_code_early_prompt_late");
		$finish;
	end

endmodule
